// ----- rtl/tfrc_pkg.sv -----
// shared types, opcode and stop cause codes for the four-register cpu step block
// no dependencies
package tfrc_pkg;

  localparam int DataDepth = 256;
  localparam int AddrW     = $clog2(DataDepth);
  localparam int NumRegs   = 4;

  localparam logic [8:0] ProgLenReset = 9'd256;

  localparam logic [3:0] OpJump  = 4'd0;
  localparam logic [3:0] OpHalt  = 4'd1;
  localparam logic [3:0] OpMovi  = 4'd2;
  localparam logic [3:0] OpNop   = 4'd3;
  localparam logic [3:0] OpMov   = 4'd4;
  localparam logic [3:0] OpAdd   = 4'd5;
  localparam logic [3:0] OpJc    = 4'd6;
  localparam logic [3:0] OpJz    = 4'd7;
  localparam logic [3:0] OpLoad  = 4'd8;
  localparam logic [3:0] OpStore = 4'd9;
  localparam logic [3:0] OpPush  = 4'd10;
  localparam logic [3:0] OpPop   = 4'd11;
  localparam logic [3:0] OpCall  = 4'd12;
  localparam logic [3:0] OpRet   = 4'd13;
  localparam logic [3:0] OpLimit = 4'd14;

  localparam logic [2:0] CauseNone      = 3'd0;
  localparam logic [2:0] CauseHalt      = 3'd1;
  localparam logic [2:0] CauseInvalid   = 3'd2;
  localparam logic [2:0] CauseEnd       = 3'd3;
  localparam logic [2:0] CauseOverflow  = 3'd4;
  localparam logic [2:0] CauseUnderflow = 3'd5;

  typedef struct packed {
    logic [7:0] instr_byte;
    logic [7:0] next_byte;
  } in_item_t;

  typedef struct packed {
    logic [8:0] next_pc;
    logic       running;
    logic [2:0] stop_cause;
    logic [7:0] bus_value;
    logic       zero_out;
    logic       carry_out;
    logic [7:0] stack_ptr_out;
    logic [7:0] reg0_out;
    logic [7:0] reg1_out;
    logic [7:0] reg2_out;
    logic [7:0] reg3_out;
  } out_item_t;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] dst;
    logic [1:0] src;
    logic [7:0] imm;
    logic       two_byte;
    logic       invalid;
  } dec_t;

  function automatic logic op_two_byte(logic [3:0] op);
    logic two;
    unique case (op)
      OpJump, OpMovi, OpJc, OpJz, OpLoad, OpStore, OpCall: two = 1'b1;
      default: two = 1'b0;
    endcase
    return two;
  endfunction

endpackage

// ----- rtl/tfrc_front.sv -----
// front end: accepts input items, decodes them and holds them in a two-entry queue
// depends on tfrc_pkg
module tfrc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tfrc_pkg::in_item_t in_item_i,
  output logic              q_valid_o,
  input  logic              q_pop_i,
  output tfrc_pkg::dec_t    q_item_o
);

  tfrc_pkg::dec_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push;
  logic           pop;
  tfrc_pkg::dec_t dec;

  always_comb begin
    dec.op       = in_item_i.instr_byte[7:4];
    dec.dst      = in_item_i.instr_byte[3:2];
    dec.src      = in_item_i.instr_byte[1:0];
    dec.imm      = in_item_i.next_byte;
    dec.two_byte = tfrc_pkg::op_two_byte(in_item_i.instr_byte[7:4]);
    dec.invalid  = (in_item_i.instr_byte[7:4] >= tfrc_pkg::OpLimit);
  end

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && (count_q != 2'd0);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= dec;
    end
  end

endmodule

// ----- rtl/tfrc_back.sv -----
// back end: data memory read, execute and writeback of one decoded item, output register
// depends on tfrc_pkg
module tfrc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [8:0]          prog_len_i,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  tfrc_pkg::dec_t      q_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tfrc_pkg::out_item_t out_item_o
);

  typedef enum logic {
    S_READ,
    S_EXEC
  } phase_e;

  localparam int AW = tfrc_pkg::AddrW;

  phase_e              phase_q;
  tfrc_pkg::dec_t      cur_q;
  logic [8:0]          pc_q, pc_d;
  logic [7:0]          gp_q [tfrc_pkg::NumRegs];
  logic [7:0]          gp_d [tfrc_pkg::NumRegs];
  logic [7:0]          sp_q, sp_d;
  logic                z_q, z_d;
  logic                c_q, c_d;
  logic [7:0]          bus_q, bus_d;
  logic                run_q, run_d;
  logic [2:0]          cause_q, cause_d;
  logic                out_valid_q;
  tfrc_pkg::out_item_t out_q, out_d;

  logic [7:0]          mem [tfrc_pkg::DataDepth];
  logic [tfrc_pkg::DataDepth-1:0] mvalid_q;
  logic [7:0]          rd_data_q;
  logic                rd_valid_q;
  logic [AW-1:0]       rd_addr;
  logic [7:0]          rd_val;
  logic                mem_we;
  logic [AW-1:0]       wr_addr;
  logic [7:0]          wr_data;

  logic                take;
  logic                commit;
  logic                jumped;
  logic                stop;
  logic [8:0]          sum;
  logic [9:0]          pc_plus1;
  logic [7:0]          sp_inc;

  assign take     = (phase_q == S_READ) && q_valid_i;
  assign q_pop_o  = take;
  assign commit   = (phase_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  assign sp_inc   = sp_q + 8'd1;
  assign rd_addr  = (q_item_i.op == tfrc_pkg::OpLoad) ? q_item_i.imm[AW-1:0] : sp_inc[AW-1:0];
  assign rd_val   = rd_valid_q ? rd_data_q : 8'd0;
  assign pc_plus1 = {1'b0, pc_q} + 10'd1;
  assign sum      = {1'b0, gp_q[cur_q.dst]} + {1'b0, gp_q[cur_q.src]};

  always_comb begin
    pc_d    = pc_q;
    gp_d    = gp_q;
    sp_d    = sp_q;
    z_d     = z_q;
    c_d     = c_q;
    bus_d   = bus_q;
    run_d   = run_q;
    cause_d = cause_q;
    mem_we  = 1'b0;
    wr_addr = cur_q.imm[AW-1:0];
    wr_data = gp_q[cur_q.src];
    jumped  = 1'b0;
    stop    = 1'b0;
    if (run_q) begin
      priority if (pc_q >= prog_len_i) begin
        stop    = 1'b1;
        cause_d = tfrc_pkg::CauseEnd;
      end else if (cur_q.invalid) begin
        stop    = 1'b1;
        cause_d = tfrc_pkg::CauseInvalid;
      end else if (cur_q.two_byte && (pc_plus1 >= {1'b0, prog_len_i})) begin
        stop    = 1'b1;
        cause_d = tfrc_pkg::CauseEnd;
      end else begin
        unique case (cur_q.op)
          tfrc_pkg::OpHalt: begin
            stop    = 1'b1;
            cause_d = tfrc_pkg::CauseHalt;
          end
          tfrc_pkg::OpJump: begin
            pc_d   = {1'b0, cur_q.imm};
            jumped = 1'b1;
          end
          tfrc_pkg::OpMovi: begin
            bus_d            = cur_q.imm;
            gp_d[cur_q.dst]  = cur_q.imm;
          end
          tfrc_pkg::OpMov: begin
            bus_d            = gp_q[cur_q.src];
            gp_d[cur_q.dst]  = gp_q[cur_q.src];
          end
          tfrc_pkg::OpAdd: begin
            bus_d            = sum[7:0];
            gp_d[cur_q.dst]  = sum[7:0];
            z_d              = (sum[7:0] == 8'd0);
            c_d              = sum[8];
          end
          tfrc_pkg::OpJc: begin
            if (c_q) begin
              pc_d   = {1'b0, cur_q.imm};
              jumped = 1'b1;
            end
          end
          tfrc_pkg::OpJz: begin
            if (z_q) begin
              pc_d   = {1'b0, cur_q.imm};
              jumped = 1'b1;
            end
          end
          tfrc_pkg::OpLoad: begin
            bus_d            = rd_val;
            gp_d[cur_q.dst]  = rd_val;
          end
          tfrc_pkg::OpStore: begin
            bus_d  = gp_q[cur_q.src];
            mem_we = 1'b1;
          end
          tfrc_pkg::OpPush: begin
            if (sp_q == 8'd0) begin
              stop    = 1'b1;
              cause_d = tfrc_pkg::CauseOverflow;
            end else begin
              bus_d   = gp_q[cur_q.src];
              mem_we  = 1'b1;
              wr_addr = sp_q[AW-1:0];
              sp_d    = sp_q - 8'd1;
            end
          end
          tfrc_pkg::OpPop: begin
            if (sp_q == 8'd255) begin
              stop    = 1'b1;
              cause_d = tfrc_pkg::CauseUnderflow;
            end else begin
              sp_d             = sp_inc;
              bus_d            = rd_val;
              gp_d[cur_q.dst]  = rd_val;
            end
          end
          tfrc_pkg::OpCall: begin
            bus_d   = pc_q[7:0] + 8'd2;
            mem_we  = 1'b1;
            wr_addr = sp_q[AW-1:0];
            wr_data = pc_q[7:0] + 8'd2;
            sp_d    = sp_q - 8'd1;
            pc_d    = {1'b0, cur_q.imm};
            jumped  = 1'b1;
          end
          tfrc_pkg::OpRet: begin
            sp_d   = sp_inc;
            bus_d  = rd_val;
            pc_d   = {1'b0, rd_val};
            jumped = 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (stop) begin
        run_d = 1'b0;
      end else if (!jumped) begin
        pc_d = pc_q + (cur_q.two_byte ? 9'd2 : 9'd1);
      end
    end
  end

  always_comb begin
    out_d.next_pc       = pc_d;
    out_d.running       = run_d;
    out_d.stop_cause    = cause_d;
    out_d.bus_value     = bus_d;
    out_d.zero_out      = z_d;
    out_d.carry_out     = c_d;
    out_d.stack_ptr_out = sp_d;
    out_d.reg0_out      = gp_d[0];
    out_d.reg1_out      = gp_d[1];
    out_d.reg2_out      = gp_d[2];
    out_d.reg3_out      = gp_d[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= S_READ;
      pc_q        <= 9'd0;
      for (int i = 0; i < tfrc_pkg::NumRegs; i++) begin
        gp_q[i] <= 8'd0;
      end
      sp_q        <= 8'd255;
      z_q         <= 1'b0;
      c_q         <= 1'b0;
      bus_q       <= 8'd0;
      run_q       <= 1'b1;
      cause_q     <= tfrc_pkg::CauseNone;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (take) begin
        phase_q <= S_EXEC;
      end else if (commit) begin
        phase_q <= S_READ;
      end
      if (commit) begin
        pc_q        <= pc_d;
        gp_q        <= gp_d;
        sp_q        <= sp_d;
        z_q         <= z_d;
        c_q         <= c_d;
        bus_q       <= bus_d;
        run_q       <= run_d;
        cause_q     <= cause_d;
        out_valid_q <= 1'b1;
        out_q       <= out_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q <= q_item_i;
    end
  end

  // data memory, entries not yet written read as zero
  always_ff @(posedge clk_i) begin
    if (commit && mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (take) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvalid_q   <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (commit && mem_we) begin
        mvalid_q[wr_addr] <= 1'b1;
      end
      if (take) begin
        rd_valid_q <= mvalid_q[rd_addr];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- rtl/tiny_four_register_cpu_step.sv -----
// top level of the four-register cpu step block: program length register and the two halves
// depends on tfrc_pkg, tfrc_front, tfrc_back
//
// Each item is one instruction: the program byte at the current pc and the byte after it.
// One result comes back per item with the new pc, run state, stop cause, bus, flags, stack
// pointer and all four registers. The execute unit reads the synchronous data memory
// (S_READ), then executes and writes back (S_EXEC); it takes no new item until the current
// one commits, and a stalled output holds it in S_EXEC. An accepted item passes through the
// queue, S_READ and S_EXEC to the output register. A two-entry queue ahead of the execute
// unit keeps input accepted while a result waits on the output. After reset the data memory
// reads as zero at once through per-entry valid bits; there is no clearing pass.
// program_length is written through the configuration channel, which is always ready.
module tiny_four_register_cpu_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tfrc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tfrc_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [8:0]          cfg_data_i
);

  logic [8:0]     prog_len_q;
  logic           q_valid;
  logic           q_pop;
  tfrc_pkg::dec_t q_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_len_q <= tfrc_pkg::ProgLenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      prog_len_q <= cfg_data_i;
    end
  end

  tfrc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  tfrc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .prog_len_i  (prog_len_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- tb/tiny_four_register_cpu_step_test.sv -----
// self-checking testbench for tiny_four_register_cpu_step: directed table, then random programs
// executed step by step against an instruction-level predictor; depends on tfrc_pkg and the rtl
`timescale 1ns / 100ps

module tiny_four_register_cpu_step_test;

  typedef struct {
    tfrc_pkg::in_item_t  item;
    bit                  typed;
    tfrc_pkg::out_item_t want;
  } dir_row_t;

  typedef enum int {
    StopHalt, StopInvalid, StopZeroLength, StopRunOff, StopNoImm, StopOverflow, StopUnderflow
  } stop_path_e;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                instr_valid = 1'b0;
  logic                instr_stall;
  tfrc_pkg::in_item_t  instr_item = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  tfrc_pkg::out_item_t result_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [8:0]          cfg_data = '0;

  bit                  idling = 1'b1;
  int unsigned         stall_left = 0;
  int                  miss_count = 0;
  tfrc_pkg::out_item_t expected_states[$];

  // predictor state
  logic [8:0] prog_len;
  logic [8:0] cpu_pc;
  logic [7:0] cpu_regs [tfrc_pkg::NumRegs];
  logic [7:0] cpu_mem [tfrc_pkg::DataDepth];
  logic [7:0] cpu_sp;
  logic       cpu_zf;
  logic       cpu_cf;
  logic [7:0] cpu_bus;
  logic       cpu_run;
  logic [2:0] cpu_cause;

  dir_row_t dir_rows [24] = '{
    '{'{{tfrc_pkg::OpNop, 4'h0}, 8'h00}, 1'b1,
      '{9'd1, 1'b1, tfrc_pkg::CauseNone, 8'h00, 1'b0, 1'b0, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{'{{tfrc_pkg::OpMovi, 2'd0, 2'd0}, 8'hFF}, 1'b1,
      '{9'd3, 1'b1, tfrc_pkg::CauseNone, 8'hFF, 1'b0, 1'b0, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00}},
    '{'{{tfrc_pkg::OpMovi, 2'd1, 2'd0}, 8'h01}, 1'b1,
      '{9'd5, 1'b1, tfrc_pkg::CauseNone, 8'h01, 1'b0, 1'b0, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h00}},
    '{'{{tfrc_pkg::OpAdd, 2'd0, 2'd1}, 8'h00}, 1'b1,
      '{9'd6, 1'b1, tfrc_pkg::CauseNone, 8'h00, 1'b1, 1'b1, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h00}},
    '{'{{tfrc_pkg::OpJc, 4'h0}, 8'h10}, 1'b1,
      '{9'h010, 1'b1, tfrc_pkg::CauseNone, 8'h00, 1'b1, 1'b1, 8'hFF, 8'h00, 8'h01, 8'h00,
        8'h00}},
    '{'{{tfrc_pkg::OpJz, 4'h0}, 8'h20}, 1'b1,
      '{9'h020, 1'b1, tfrc_pkg::CauseNone, 8'h00, 1'b1, 1'b1, 8'hFF, 8'h00, 8'h01, 8'h00,
        8'h00}},
    '{'{{tfrc_pkg::OpMov, 2'd3, 2'd1}, 8'h00}, 1'b0, '0},
    '{'{{tfrc_pkg::OpAdd, 2'd3, 2'd3}, 8'h00}, 1'b0, '0},
    '{'{{tfrc_pkg::OpJc, 4'h0}, 8'h00}, 1'b0, '0},
    '{'{{tfrc_pkg::OpJz, 4'h0}, 8'hFF}, 1'b0, '0},
    '{'{{tfrc_pkg::OpStore, 2'd0, 2'd1}, 8'hFF}, 1'b0, '0},
    '{'{{tfrc_pkg::OpLoad, 2'd2, 2'd0}, 8'hFF}, 1'b0, '0},
    '{'{{tfrc_pkg::OpLoad, 2'd2, 2'd0}, 8'h00}, 1'b0, '0},
    '{'{{tfrc_pkg::OpPush, 2'd0, 2'd3}, 8'h00}, 1'b0, '0},
    '{'{{tfrc_pkg::OpPush, 2'd0, 2'd1}, 8'h00}, 1'b0, '0},
    '{'{{tfrc_pkg::OpPop, 2'd0, 2'd0}, 8'h00}, 1'b0, '0},
    '{'{{tfrc_pkg::OpCall, 4'h0}, 8'h40}, 1'b0, '0},
    '{'{{tfrc_pkg::OpRet, 4'h0}, 8'h00}, 1'b0, '0},
    '{'{{tfrc_pkg::OpPop, 2'd2, 2'd0}, 8'h00}, 1'b0, '0},
    '{'{{tfrc_pkg::OpMovi, 2'd3, 2'd0}, 8'h80}, 1'b0, '0},
    '{'{{tfrc_pkg::OpAdd, 2'd3, 2'd3}, 8'h00}, 1'b0, '0},
    '{'{{tfrc_pkg::OpNop, 4'hF}, 8'hFF}, 1'b0, '0},
    '{'{{tfrc_pkg::OpJump, 4'h0}, 8'hFE}, 1'b0, '0},
    '{'{{tfrc_pkg::OpJump, 4'hF}, 8'h00}, 1'b0, '0}
  };

  tiny_four_register_cpu_step DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (instr_valid),
    .in_stall_o  (instr_stall),
    .in_item_i   (instr_item),
    .out_valid_o (result_valid),
    .out_stall_i (result_stall),
    .out_item_o  (result_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("tiny_four_register_cpu_step: mismatch");
    $finish;
  end

  function automatic int instr_len(logic [3:0] op);
    case (op)
      tfrc_pkg::OpJump, tfrc_pkg::OpMovi, tfrc_pkg::OpJc, tfrc_pkg::OpJz, tfrc_pkg::OpLoad,
      tfrc_pkg::OpStore, tfrc_pkg::OpCall: return 2;
      default: return 1;
    endcase
  endfunction

  function automatic void halt_with(logic [2:0] cause);
    cpu_run = 1'b0;
    cpu_cause = cause;
  endfunction

  function automatic tfrc_pkg::out_item_t exec_instr(tfrc_pkg::in_item_t it);
    logic [3:0]          op;
    logic [1:0]          dst;
    logic [1:0]          src;
    logic [7:0]          imm;
    logic [8:0]          sum;
    int                  len;
    bit                  taken;
    tfrc_pkg::out_item_t r;
    op = it.instr_byte[7:4];
    dst = it.instr_byte[3:2];
    src = it.instr_byte[1:0];
    imm = it.next_byte;
    len = instr_len(op);
    taken = 1'b0;
    if (cpu_run) begin
      if (cpu_pc >= prog_len) begin
        halt_with(tfrc_pkg::CauseEnd);
      end else if (op >= tfrc_pkg::OpLimit) begin
        halt_with(tfrc_pkg::CauseInvalid);
      end else if (len == 2 && int'(cpu_pc) + 1 >= int'(prog_len)) begin
        halt_with(tfrc_pkg::CauseEnd);
      end else begin
        case (op)
          tfrc_pkg::OpHalt: halt_with(tfrc_pkg::CauseHalt);
          tfrc_pkg::OpJump: begin
            cpu_pc = {1'b0, imm};
            taken = 1'b1;
          end
          tfrc_pkg::OpMovi: begin
            cpu_bus = imm;
            cpu_regs[dst] = cpu_bus;
          end
          tfrc_pkg::OpMov: begin
            cpu_bus = cpu_regs[src];
            cpu_regs[dst] = cpu_bus;
          end
          tfrc_pkg::OpAdd: begin
            sum = {1'b0, cpu_regs[dst]} + {1'b0, cpu_regs[src]};
            cpu_bus = sum[7:0];
            cpu_regs[dst] = cpu_bus;
            cpu_zf = (sum[7:0] == 8'h00);
            cpu_cf = sum[8];
          end
          tfrc_pkg::OpJc: begin
            if (cpu_cf) begin
              cpu_pc = {1'b0, imm};
              taken = 1'b1;
            end
          end
          tfrc_pkg::OpJz: begin
            if (cpu_zf) begin
              cpu_pc = {1'b0, imm};
              taken = 1'b1;
            end
          end
          tfrc_pkg::OpLoad: begin
            cpu_bus = cpu_mem[imm];
            cpu_regs[dst] = cpu_bus;
          end
          tfrc_pkg::OpStore: begin
            cpu_bus = cpu_regs[src];
            cpu_mem[imm] = cpu_bus;
          end
          tfrc_pkg::OpPush: begin
            if (cpu_sp == 8'h00) begin
              halt_with(tfrc_pkg::CauseOverflow);
            end else begin
              cpu_bus = cpu_regs[src];
              cpu_mem[cpu_sp] = cpu_bus;
              cpu_sp = cpu_sp - 8'd1;
            end
          end
          tfrc_pkg::OpPop: begin
            if (cpu_sp == 8'hFF) begin
              halt_with(tfrc_pkg::CauseUnderflow);
            end else begin
              cpu_sp = cpu_sp + 8'd1;
              cpu_bus = cpu_mem[cpu_sp];
              cpu_regs[dst] = cpu_bus;
            end
          end
          tfrc_pkg::OpCall: begin
            cpu_bus = cpu_pc[7:0] + 8'd2;
            cpu_mem[cpu_sp] = cpu_bus;
            cpu_sp = cpu_sp - 8'd1;
            cpu_pc = {1'b0, imm};
            taken = 1'b1;
          end
          tfrc_pkg::OpRet: begin
            cpu_sp = cpu_sp + 8'd1;
            cpu_bus = cpu_mem[cpu_sp];
            cpu_pc = {1'b0, cpu_bus};
            taken = 1'b1;
          end
          default: ;
        endcase
        if (cpu_run && !taken) cpu_pc = cpu_pc + 9'(len);
      end
    end
    r.next_pc = cpu_pc;
    r.running = cpu_run;
    r.stop_cause = cpu_cause;
    r.bus_value = cpu_bus;
    r.zero_out = cpu_zf;
    r.carry_out = cpu_cf;
    r.stack_ptr_out = cpu_sp;
    r.reg0_out = cpu_regs[0];
    r.reg1_out = cpu_regs[1];
    r.reg2_out = cpu_regs[2];
    r.reg3_out = cpu_regs[3];
    return r;
  endfunction

  // true when the instruction runs without stopping and the next fetch has room for an immediate
  function automatic bit keeps_running(tfrc_pkg::in_item_t it);
    logic [3:0] op;
    logic [7:0] top;
    int         len;
    int         npc;
    op = it.instr_byte[7:4];
    top = cpu_sp + 8'd1;
    if (op >= tfrc_pkg::OpLimit || op == tfrc_pkg::OpHalt) return 1'b0;
    len = instr_len(op);
    if (int'(cpu_pc) + len - 1 >= int'(prog_len)) return 1'b0;
    if (op == tfrc_pkg::OpPush && cpu_sp == 8'h00) return 1'b0;
    if (op == tfrc_pkg::OpPop && cpu_sp == 8'hFF) return 1'b0;
    case (op)
      tfrc_pkg::OpJump, tfrc_pkg::OpCall: npc = int'(it.next_byte);
      tfrc_pkg::OpJc: npc = cpu_cf ? int'(it.next_byte) : int'(cpu_pc) + len;
      tfrc_pkg::OpJz: npc = cpu_zf ? int'(it.next_byte) : int'(cpu_pc) + len;
      tfrc_pkg::OpRet: npc = int'(cpu_mem[top]);
      default: npc = int'(cpu_pc) + len;
    endcase
    return npc + 1 < int'(prog_len);
  endfunction

  function automatic tfrc_pkg::in_item_t pick_instr(int want);
    tfrc_pkg::in_item_t it;
    int                 hi;
    hi = int'(prog_len) - 2;
    if (hi > 255) hi = 255;
    for (int k = 0; k < 64; k++) begin
      it.instr_byte = 8'($urandom);
      it.next_byte = 8'($urandom);
      if (want >= 0) it.instr_byte[7:4] = 4'(want);
      case (it.instr_byte[7:4])
        tfrc_pkg::OpJump, tfrc_pkg::OpJc, tfrc_pkg::OpJz, tfrc_pkg::OpCall: begin
          if (hi >= 0 && $urandom_range(0, 3) != 0) it.next_byte = 8'($urandom_range(0, hi));
        end
        default: ;
      endcase
      if (keeps_running(it)) return it;
    end
    it.instr_byte = {tfrc_pkg::OpJump, 4'($urandom)};
    it.next_byte = 8'h00;
    return it;
  endfunction

  task automatic issue_instr(tfrc_pkg::in_item_t it, bit typed = 1'b0,
                             tfrc_pkg::out_item_t want = '0);
    int                  gap;
    tfrc_pkg::out_item_t predicted;
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      instr_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr_valid <= 1'b1;
    instr_item <= it;
    @(posedge clk);
    while (instr_stall) @(posedge clk);
    predicted = exec_instr(it);
    expected_states.push_back(typed ? want : predicted);
  endtask

  task automatic settle();
    instr_valid <= 1'b0;
    while (expected_states.size() != 0) @(posedge clk);
  endtask

  // park the pc at 0 first so a shorter program still holds it
  task automatic set_prog_len(logic [8:0] len);
    if (int'(cpu_pc) + 1 >= int'(len)) issue_instr('{{tfrc_pkg::OpJump, 4'h0}, 8'h00});
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    prog_len = len;
  endtask

  task automatic run_random(int count);
    idling <= ($urandom_range(0, 3) != 0);
    repeat (count) issue_instr(pick_instr(-1));
  endtask

  task automatic report_miss(string what, tfrc_pkg::out_item_t want,
                             tfrc_pkg::out_item_t got);
    miss_count++;
    if (miss_count <= 10) $display("%0t %s: expected %h, got %h", $time, what, want, got);
  endtask

  task automatic compare_state(tfrc_pkg::out_item_t want, tfrc_pkg::out_item_t got);
    if (got !== want) report_miss("result item", want, got);
  endtask

  always @(posedge clk) begin
    if (!idling) begin
      result_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      result_stall <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && result_valid && !result_stall) begin
      if (expected_states.size() == 0) begin
        report_miss("item with nothing expected", '0, result_item);
      end else begin
        compare_state(expected_states.pop_front(), result_item);
      end
    end
  end

  initial begin
    stop_path_e path;
    prog_len = tfrc_pkg::ProgLenReset;
    cpu_pc = '0;
    foreach (cpu_regs[i]) cpu_regs[i] = '0;
    foreach (cpu_mem[i]) cpu_mem[i] = '0;
    cpu_sp = 8'hFF;
    cpu_zf = 1'b0;
    cpu_cf = 1'b0;
    cpu_bus = '0;
    cpu_run = 1'b1;
    cpu_cause = tfrc_pkg::CauseNone;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) issue_instr(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    settle();

    // full 9-bit length lets the pc climb past 255
    set_prog_len(9'h1FF);
    issue_instr('{{tfrc_pkg::OpJump, 4'h0}, 8'hF0});
    repeat (24) issue_instr(pick_instr($urandom_range(tfrc_pkg::OpMovi, tfrc_pkg::OpAdd)));
    run_random(400);

    set_prog_len(9'd2);
    run_random(30);

    set_prog_len(9'($urandom_range(3, 255)));
    run_random(400);

    set_prog_len(tfrc_pkg::ProgLenReset);
    idling <= 1'b0;
    repeat (700) issue_instr(pick_instr(-1));

    path = stop_path_e'($urandom_range(0, 6));
    case (path)
      StopHalt: issue_instr('{{tfrc_pkg::OpHalt, 4'($urandom)}, 8'($urandom)});
      StopInvalid: begin
        issue_instr('{{4'($urandom_range(tfrc_pkg::OpLimit, 15)), 4'($urandom)},
                      8'($urandom)});
      end
      StopZeroLength: set_prog_len(9'd0);
      StopRunOff: begin
        issue_instr('{{tfrc_pkg::OpJump, 4'h0}, 8'hFE});
        issue_instr('{{tfrc_pkg::OpNop, 4'($urandom)}, 8'($urandom)});
        issue_instr('{{tfrc_pkg::OpNop, 4'($urandom)}, 8'($urandom)});
      end
      StopNoImm: begin
        issue_instr('{{tfrc_pkg::OpJump, 4'h0}, 8'hFF});
        issue_instr('{{tfrc_pkg::OpMovi, 4'($urandom)}, 8'($urandom)});
      end
      StopOverflow: begin
        while (cpu_sp != 8'h00) issue_instr(pick_instr(tfrc_pkg::OpPush));
        issue_instr('{{tfrc_pkg::OpPush, 4'($urandom)}, 8'($urandom)});
      end
      StopUnderflow: begin
        while (cpu_sp != 8'hFF) issue_instr(pick_instr(tfrc_pkg::OpPop));
        issue_instr('{{tfrc_pkg::OpPop, 4'($urandom)}, 8'($urandom)});
      end
      default: ;
    endcase
    // a stopped machine holds its state whatever comes in
    repeat (3) issue_instr(tfrc_pkg::in_item_t'(16'($urandom)));

    settle();
    repeat (8) @(posedge clk);
    if (miss_count == 0 && expected_states.size() == 0) begin
      $display("tiny_four_register_cpu_step: match");
    end else begin
      $display("tiny_four_register_cpu_step: mismatch");
    end
    $finish;
  end

endmodule

// ----- tiny_four_register_cpu_step.f -----
rtl/tfrc_pkg.sv
rtl/tfrc_front.sv
rtl/tfrc_back.sv
rtl/tiny_four_register_cpu_step.sv
tb/tiny_four_register_cpu_step_test.sv
